@@ sv/vtpg_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// Video test pattern generator package
// Shared constants, register indexes, pattern codes and the command/status
// structs between the controller and the datapath.
// ---------------------------------------------------------------------------
package vtpg_pkg;

	localparam int MODE_W     = 3;
	localparam int CFG_DIM_W  = 13;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int SEED_W     = 32;
	localparam int COLOR_W    = 8;
	localparam int SEL_W      = 2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SEED   = 2'd3;

	// Pattern codes.
	localparam logic [MODE_W-1:0] MODE_SOLID    = 3'd0;
	localparam logic [MODE_W-1:0] MODE_GRADIENT = 3'd1;
	localparam logic [MODE_W-1:0] MODE_CHECKER  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_NOISE    = 3'd3;
	localparam logic [MODE_W-1:0] MODE_DIAGONAL = 3'd4;

	// Gradient component selects for the shared divider.
	localparam logic [SEL_W-1:0] SEL_RED   = 2'd0;
	localparam logic [SEL_W-1:0] SEL_GREEN = 2'd1;
	localparam logic [SEL_W-1:0] SEL_BLUE  = 2'd2;

	localparam logic [COLOR_W-1:0] SOLID_RED   = 8'd17;
	localparam logic [COLOR_W-1:0] SOLID_GREEN = 8'd34;
	localparam logic [COLOR_W-1:0] SOLID_BLUE  = 8'd51;
	localparam logic [COLOR_W-1:0] COLOR_MAX   = 8'd255;
	localparam logic [COLOR_W-1:0] COLOR_MIN   = 8'd0;

	localparam logic [SEED_W-1:0] LCG_MUL    = 32'd1664525;
	localparam logic [SEED_W-1:0] LCG_ADD    = 32'd1013904223;
	localparam logic [SEED_W-1:0] SEED_RESET = 32'd1;

	// Checker squares are 8 pixels wide.
	localparam int CHECK_SHIFT = 3;

	localparam int DIM_RESET = 64;

	typedef struct packed {
		logic             accept;
		logic             div_start;
		logic [SEL_W-1:0] div_sel;
		logic             grad_cap;
		logic             load_out;
	} cmd_t;

	typedef struct packed {
		logic grad_mode;
		logic div_done;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

@@ sv/vtpg_div.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// Saturating divider
// Restoring divider, one quotient bit per cycle, giving min(num/den, 255)
// and 0 for a zero divisor.
// ---------------------------------------------------------------------------
module vtpg_div #(
	parameter int DIM_W = 12
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [DIM_W+8:0]              num,
	input  wire logic [DIM_W:0]                den,
	output logic                               done,
	output logic [vtpg_pkg::COLOR_W-1:0]       quo
);
	import vtpg_pkg::*;

	localparam int NUM_W = DIM_W + 9;
	localparam int CNT_W = $clog2(COLOR_W);

	logic [NUM_W-1:0]   rem_q;
	logic [NUM_W-1:0]   dsh_q;
	logic [COLOR_W-1:0] q_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;
	logic               sat_q;
	logic               zero_q;
	logic [NUM_W-1:0]   den_ext;

	assign den_ext = NUM_W'(den);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(COLOR_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= num;
			dsh_q  <= den_ext << (COLOR_W - 1);
			q_q    <= '0;
			zero_q <= (den == '0);
			// A quotient of 256 or more saturates.
			sat_q  <= (num >= (den_ext << COLOR_W));
		end else if (busy_q) begin
			if (rem_q >= dsh_q) begin
				rem_q <= rem_q - dsh_q;
				q_q   <= {q_q[COLOR_W-2:0], 1'b1};
			end else begin
				q_q   <= {q_q[COLOR_W-2:0], 1'b0};
			end
			dsh_q <= dsh_q >> 1;
		end
	end

	assign done = done_q;
	assign quo  = zero_q ? COLOR_MIN : (sat_q ? COLOR_MAX : q_q);

endmodule
`default_nettype wire

@@ sv/vtpg_ctrl.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// Pattern generator controller
// Sequences one pixel: accept, optional three gradient divisions, then
// hand-off to the output register.
// ---------------------------------------------------------------------------
module vtpg_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  vtpg_pkg::sts_t     sts,
	output vtpg_pkg::cmd_t     cmd
);
	import vtpg_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_FINISH
	} state_t;

	state_t           state_q;
	logic             start_q;
	logic [SEL_W-1:0] sel_q;
	logic             accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd.accept    = accept;
		cmd.div_start = start_q;
		cmd.div_sel   = sel_q;
		cmd.grad_cap  = (state_q == ST_DIVIDE) && sts.div_done;
		cmd.load_out  = (state_q == ST_FINISH) && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			start_q <= 1'b0;
			sel_q   <= SEL_RED;
		end else begin
			start_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (sts.grad_mode) begin
							state_q <= ST_DIVIDE;
							start_q <= 1'b1;
							sel_q   <= SEL_RED;
						end else begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_DIVIDE: begin
					if (sts.div_done) begin
						if (sel_q == SEL_BLUE) begin
							state_q <= ST_FINISH;
						end else begin
							sel_q   <= sel_q + 1'b1;
							start_q <= 1'b1;
						end
					end
				end
				ST_FINISH: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

@@ sv/vtpg_datapath.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// Pattern generator datapath
// Configuration registers, raster counters, noise LCG, pattern logic and
// the output register.
// ---------------------------------------------------------------------------
module vtpg_datapath #(
	parameter int unsigned MAX_DIM = 4096
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_valid,
	input  wire logic [vtpg_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [vtpg_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  wire logic                                 restart,
	input  vtpg_pkg::cmd_t                            cmd,
	output vtpg_pkg::sts_t                            sts,
	output logic [$clog2(MAX_DIM)+8:0]                div_num,
	output logic [$clog2(MAX_DIM):0]                  div_den,
	input  wire logic                                 div_done,
	input  wire logic [vtpg_pkg::COLOR_W-1:0]         div_quo,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic [vtpg_pkg::COLOR_W-1:0]              red,
	output logic [vtpg_pkg::COLOR_W-1:0]              green,
	output logic [vtpg_pkg::COLOR_W-1:0]              blue,
	output logic                                      line_end,
	output logic                                      frame_end
);
	import vtpg_pkg::*;

	localparam int DIM_W   = $clog2(MAX_DIM);
	localparam int NUM_W   = DIM_W + 9;
	localparam int RST_DIM = (DIM_RESET > int'(MAX_DIM)) ? int'(MAX_DIM) : DIM_RESET;

	// Configuration: dimensions are held as clamped size minus one.
	logic [MODE_W-1:0]    mode_q;
	logic [DIM_W-1:0]     wm1_q;
	logic [DIM_W-1:0]     hm1_q;
	logic [SEED_W-1:0]    seed_q;
	logic [CFG_DIM_W-1:0] cfg_dim;
	logic [DIM_W-1:0]     cfg_dim_m1;

	// Raster and noise state.
	logic [DIM_W-1:0]  col_q;
	logic [DIM_W-1:0]  row_q;
	logic [SEED_W-1:0] lcg_q;
	logic [DIM_W-1:0]  x_cur;
	logic [DIM_W-1:0]  y_cur;
	logic [SEED_W-1:0] lcg_cur;
	logic              le_cur;
	logic              fe_cur;

	// Current pixel.
	logic [DIM_W-1:0] x_s1;
	logic [DIM_W-1:0] y_s1;
	logic             le_s1;
	logic             fe_s1;

	logic [COLOR_W-1:0] grad_r_q;
	logic [COLOR_W-1:0] grad_g_q;
	logic [COLOR_W-1:0] grad_b_q;

	logic [DIM_W:0]     base;
	logic [DIM_W-1:0]   chk_x;
	logic [DIM_W-1:0]   chk_y;
	logic [DIM_W-1:0]   dxy;
	logic [COLOR_W-1:0] pix_r;
	logic [COLOR_W-1:0] pix_g;
	logic [COLOR_W-1:0] pix_b;
	logic               out_valid_q;

	assign cfg_dim = cfg_data[CFG_DIM_W-1:0];

	always_comb begin
		if (cfg_dim == '0) begin
			cfg_dim_m1 = '0;
		end else if (32'(cfg_dim) > 32'(MAX_DIM)) begin
			cfg_dim_m1 = DIM_W'(MAX_DIM - 1);
		end else begin
			cfg_dim_m1 = DIM_W'(cfg_dim - 1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_SOLID;
			wm1_q  <= DIM_W'(RST_DIM - 1);
			hm1_q  <= DIM_W'(RST_DIM - 1);
			seed_q <= SEED_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_MODE:   mode_q <= cfg_data[MODE_W-1:0];
				CFG_WIDTH:  wm1_q  <= cfg_dim_m1;
				CFG_HEIGHT: hm1_q  <= cfg_dim_m1;
				CFG_SEED:   seed_q <= cfg_data[SEED_W-1:0];
				default: ;
			endcase
		end
	end

	// A restart moves to pixel 0,0 and reloads the seed before this pixel.
	assign x_cur   = restart ? '0 : col_q;
	assign y_cur   = restart ? '0 : row_q;
	assign lcg_cur = restart ? seed_q : lcg_q;
	assign le_cur  = (x_cur >= wm1_q);
	assign fe_cur  = le_cur && (y_cur >= hm1_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			lcg_q <= SEED_RESET;
		end else if (cmd.accept) begin
			if (le_cur) begin
				col_q <= '0;
				row_q <= fe_cur ? '0 : y_cur + 1'b1;
			end else begin
				col_q <= x_cur + 1'b1;
				row_q <= y_cur;
			end
			if (mode_q == MODE_NOISE) begin
				lcg_q <= lcg_cur * LCG_MUL + LCG_ADD;
			end else begin
				lcg_q <= lcg_cur;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			x_s1  <= x_cur;
			y_s1  <= y_cur;
			le_s1 <= le_cur;
			fe_s1 <= fe_cur;
		end
	end

	// Gradient operands: component value times 255 over its span.
	always_comb begin
		case (cmd.div_sel)
			SEL_RED: begin
				base    = {1'b0, x_s1};
				div_den = {1'b0, wm1_q};
			end
			SEL_GREEN: begin
				base    = {1'b0, y_s1};
				div_den = {1'b0, hm1_q};
			end
			default: begin
				base    = {1'b0, x_s1} + {1'b0, y_s1};
				div_den = {1'b0, wm1_q} + {1'b0, hm1_q};
			end
		endcase
		div_num = (NUM_W'(base) << COLOR_W) - NUM_W'(base);
	end

	always_ff @(posedge clk) begin
		if (cmd.grad_cap) begin
			case (cmd.div_sel)
				SEL_RED:   grad_r_q <= div_quo;
				SEL_GREEN: grad_g_q <= div_quo;
				default:   grad_b_q <= div_quo;
			endcase
		end
	end

	assign chk_x = x_s1 >> CHECK_SHIFT;
	assign chk_y = y_s1 >> CHECK_SHIFT;
	assign dxy   = (x_s1 >= y_s1) ? x_s1 - y_s1 : y_s1 - x_s1;

	always_comb begin
		pix_r = COLOR_MIN;
		pix_g = COLOR_MIN;
		pix_b = COLOR_MIN;
		unique case (mode_q)
			MODE_SOLID: begin
				pix_r = SOLID_RED;
				pix_g = SOLID_GREEN;
				pix_b = SOLID_BLUE;
			end
			MODE_GRADIENT: begin
				pix_r = grad_r_q;
				pix_g = grad_g_q;
				pix_b = grad_b_q;
			end
			MODE_CHECKER: begin
				if (chk_x[0] ^ chk_y[0]) begin
					pix_r = COLOR_MAX;
					pix_g = COLOR_MAX;
					pix_b = COLOR_MAX;
				end
			end
			MODE_NOISE: begin
				pix_r = lcg_q[7:0];
				pix_g = lcg_q[15:8];
				pix_b = lcg_q[23:16];
			end
			MODE_DIAGONAL: begin
				if (dxy <= DIM_W'(1)) begin
					pix_r = COLOR_MAX;
					pix_g = COLOR_MAX;
					pix_b = COLOR_MAX;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			red       <= pix_r;
			green     <= pix_g;
			blue      <= pix_b;
			line_end  <= le_s1;
			frame_end <= fe_s1;
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		sts.grad_mode = (mode_q == MODE_GRADIENT);
		sts.div_done  = div_done;
		sts.out_free  = !out_valid_q || out_ready;
	end

endmodule
`default_nettype wire

@@ sv/video_test_pattern_generator_top.sv @@
// A transfer moves the controller from the idle state to the finish state, or in gradient
// mode first to the divide state, and the output register is loaded in finish once the output is free.
// No new transfer is taken until that load; gradient mode first runs the shared
// 8-step divider once for each color component.
// The next transfer is taken while a finished pixel still waits at the output.
// Reset clears counters, LCG state and configuration to their defaults at once.
`default_nettype none
// ---------------------------------------------------------------------------
// Video test pattern generator
// Raster RGB pattern source with line and frame end marks.
// ---------------------------------------------------------------------------
module video_test_pattern_generator_top #(
	parameter int unsigned MAX_DIM = 4096
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [vtpg_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [vtpg_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic                                 restart,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic [vtpg_pkg::COLOR_W-1:0]              red,
	output logic [vtpg_pkg::COLOR_W-1:0]              green,
	output logic [vtpg_pkg::COLOR_W-1:0]              blue,
	output logic                                      line_end,
	output logic                                      frame_end
);
	import vtpg_pkg::*;

	localparam int DIM_W = $clog2(MAX_DIM);

	cmd_t               cmd;
	sts_t               sts;
	logic [DIM_W+8:0]   div_num;
	logic [DIM_W:0]     div_den;
	logic               div_done;
	logic [COLOR_W-1:0] div_quo;

	assign cfg_ready = 1'b1;

	vtpg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	vtpg_div #(
		.DIM_W (DIM_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	vtpg_datapath #(
		.MAX_DIM (MAX_DIM)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.restart   (restart),
		.cmd       (cmd),
		.sts       (sts),
		.div_num   (div_num),
		.div_den   (div_den),
		.div_done  (div_done),
		.div_quo   (div_quo),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.line_end  (line_end),
		.frame_end (frame_end)
	);

	// The block is not ready in the cycle after a transfer.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> !in_ready)
		else $error("input ready right after a transfer");

	// A division never starts in the cycle of a new transfer.
	a_no_start_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !cmd.accept)
		else $error("division started during a transfer");

	// A freshly started division cannot finish on the next cycle.
	a_div_not_instant: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> !div_done)
		else $error("division finished too early");

	// Loading the output register always presents a pixel.
	a_load_shows_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> out_valid)
		else $error("output load did not raise out_valid");

endmodule
`default_nettype wire

@@ verif/tb_video_test_pattern_generator_top.sv @@
// ---------------------------------------------------------------------------
// Video test pattern generator testbench
// Drives restart ticks and register writes, with random idle gaps on the tick
// input and random stalls at the output. A model of the raster counters, the
// noise generator and the five patterns predicts each pixel, and every output
// transfer is compared against the oldest prediction.
// ---------------------------------------------------------------------------
module tb_video_test_pattern_generator_top;
	timeunit 1ns;
	timeprecision 1ps;

	import vtpg_pkg::*;

	localparam int unsigned PIX_MAX_DIM = 4096;
	localparam int unsigned RANDOM_PIXELS = 950;

	// Mode codes that the block does not define; they give black pixels.
	localparam logic [MODE_W-1:0] MODE_SPARE_LO  = 3'd5;
	localparam logic [MODE_W-1:0] MODE_SPARE_MID = 3'd6;
	localparam logic [MODE_W-1:0] MODE_SPARE_HI  = 3'd7;

	typedef struct packed {
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
		logic               line_end;
		logic               frame_end;
	} pixel_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic                  restart;
	logic                  out_valid;
	logic                  out_ready;
	logic [COLOR_W-1:0]    red;
	logic [COLOR_W-1:0]    green;
	logic [COLOR_W-1:0]    blue;
	logic                  line_end;
	logic                  frame_end;

	// Shadow of the registers and of the raster state.
	logic [MODE_W-1:0]    mode_q;
	logic [CFG_DIM_W-1:0] width_q;
	logic [CFG_DIM_W-1:0] height_q;
	logic [SEED_W-1:0]    seed_q;
	int unsigned          col_q;
	int unsigned          row_q;
	logic [SEED_W-1:0]    lcg_q;

	pixel_t      pixels_due[$];
	int          err_count = 0;
	int unsigned random_sent = 0;
	bit          tx_idle_on = 1'b1;
	bit          rx_idle_on = 1'b1;

	video_test_pattern_generator_top #(
		.MAX_DIM(PIX_MAX_DIM)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.restart  (restart),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.red      (red),
		.green    (green),
		.blue     (blue),
		.line_end (line_end),
		.frame_end(frame_end)
	);

	always #10 clk = ~clk;

	function automatic int unsigned clamp_dim(input int unsigned v);
		if (v == 0) return 1;
		if (v > PIX_MAX_DIM) return PIX_MAX_DIM;
		return v;
	endfunction

	function automatic logic [COLOR_W-1:0] ramp_level(input int unsigned num,
			input int unsigned den);
		int unsigned q;
		if (den == 0) return COLOR_MIN;
		q = (num * 255) / den;
		return (q > 255) ? COLOR_MAX : q[COLOR_W-1:0];
	endfunction

	function automatic void reset_model();
		mode_q   = MODE_SOLID;
		width_q  = CFG_DIM_W'(DIM_RESET);
		height_q = CFG_DIM_W'(DIM_RESET);
		seed_q   = SEED_RESET;
		col_q    = 0;
		row_q    = 0;
		lcg_q    = SEED_RESET;
	endfunction

	// Works out the pixel for one tick and advances the raster state.
	function automatic pixel_t next_pixel(input logic rs);
		int unsigned  w;
		int unsigned  h;
		int unsigned  x;
		int unsigned  y;
		int unsigned  gap_xy;
		logic [COLOR_W-1:0] shade;
		pixel_t       px;
		w = clamp_dim(32'(width_q));
		h = clamp_dim(32'(height_q));
		if (rs) begin
			lcg_q = seed_q;
			col_q = 0;
			row_q = 0;
		end
		x = col_q;
		y = row_q;
		px = '0;
		case (mode_q)
			MODE_SOLID: begin
				px.red   = SOLID_RED;
				px.green = SOLID_GREEN;
				px.blue  = SOLID_BLUE;
			end
			MODE_GRADIENT: begin
				px.red   = ramp_level(x, w - 1);
				px.green = ramp_level(y, h - 1);
				px.blue  = ramp_level(x + y, w + h - 2);
			end
			MODE_CHECKER: begin
				shade = (((x >> CHECK_SHIFT) ^ (y >> CHECK_SHIFT)) & 1) ? COLOR_MAX : COLOR_MIN;
				px.red   = shade;
				px.green = shade;
				px.blue  = shade;
			end
			MODE_NOISE: begin
				lcg_q    = lcg_q * LCG_MUL + LCG_ADD;
				px.red   = lcg_q[7:0];
				px.green = lcg_q[15:8];
				px.blue  = lcg_q[23:16];
			end
			MODE_DIAGONAL: begin
				gap_xy = (x >= y) ? x - y : y - x;
				shade  = (gap_xy <= 1) ? COLOR_MAX : COLOR_MIN;
				px.red   = shade;
				px.green = shade;
				px.blue  = shade;
			end
			default: ;
		endcase
		// A counter left past the frame by a shrink counts as the last one.
		px.line_end  = (x >= w - 1);
		px.frame_end = px.line_end && (y >= h - 1);
		if (px.line_end) begin
			col_q = 0;
			row_q = px.frame_end ? 0 : y + 1;
		end else begin
			col_q = x + 1;
		end
		return px;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_MODE:   mode_q = data[MODE_W-1:0];
			CFG_WIDTH:  width_q = data[CFG_DIM_W-1:0];
			CFG_HEIGHT: height_q = data[CFG_DIM_W-1:0];
			default:    seed_q = data;
		endcase
	endtask

	// Presents one tick and records its prediction once the transfer happens.
	// Valid is left high so that a back-to-back tick keeps it asserted.
	task automatic send_pixel(input logic rs);
		int unsigned gap;
		gap = tx_idle_on ? $urandom_range(0, 15) : 0;
		if (cfg_valid) cfg_valid <= 1'b0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		restart  <= rs;
		do @(posedge clk); while (!in_ready);
		pixels_due.push_back(next_pixel(rs));
	endtask

	// Must be followed by a register write or a wait before the next tick.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pixels_due.size() != 0) @(posedge clk);
	endtask

	function automatic logic [CFG_DATA_W-1:0] dim_word(input int unsigned d);
		logic [CFG_DATA_W-1:0] word;
		word = $urandom_range(0, 1) ? $urandom() : '0;
		word[CFG_DIM_W-1:0] = d[CFG_DIM_W-1:0];
		return word;
	endfunction

	function automatic logic [CFG_DATA_W-1:0] mode_word(input logic [MODE_W-1:0] m);
		logic [CFG_DATA_W-1:0] word;
		word = $urandom_range(0, 1) ? $urandom() : '0;
		word[MODE_W-1:0] = m;
		return word;
	endfunction

	function automatic int unsigned pick_dim();
		int unsigned k;
		k = $urandom_range(0, 99);
		if (k < 4) return 0;
		if (k < 7) return $urandom_range(PIX_MAX_DIM + 1, 8191);
		if (k < 9) return PIX_MAX_DIM;
		if (k < 25) return $urandom_range(13, 40);
		return $urandom_range(1, 12);
	endfunction

	function automatic logic [MODE_W-1:0] pick_mode();
		int unsigned k;
		k = $urandom_range(0, 20);
		if (k < 4) return MODE_SOLID;
		if (k < 8) return MODE_GRADIENT;
		if (k < 12) return MODE_CHECKER;
		if (k < 16) return MODE_NOISE;
		if (k < 20) return MODE_DIAGONAL;
		case ($urandom_range(0, 2))
			0: return MODE_SPARE_LO;
			1: return MODE_SPARE_MID;
			default: return MODE_SPARE_HI;
		endcase
	endfunction

	task automatic test_default_solid();
		send_pixel(1'b0);
		send_pixel(1'b1);
	endtask

	// Width and height of zero act as one, so every gradient divisor is zero.
	task automatic test_gradient_zero_divisor();
		wait_idle();
		write_reg(CFG_MODE, CFG_DATA_W'(MODE_GRADIENT));
		write_reg(CFG_WIDTH, 0);
		write_reg(CFG_HEIGHT, 0);
		send_pixel(1'b1);
	endtask

	// Shrinking the frame mid-line leaves the column past the new end, so
	// the next pixel closes the line and frame and the red and blue ramps saturate.
	task automatic test_gradient_shrink();
		wait_idle();
		write_reg(CFG_WIDTH, 5);
		write_reg(CFG_HEIGHT, 4);
		send_pixel(1'b1);
		send_pixel(1'b0);
		send_pixel(1'b0);
		wait_idle();
		write_reg(CFG_WIDTH, 2);
		write_reg(CFG_HEIGHT, 1);
		send_pixel(1'b0);
	endtask

	task automatic test_checker_oversize();
		wait_idle();
		write_reg(CFG_MODE, CFG_DATA_W'(MODE_CHECKER));
		write_reg(CFG_WIDTH, 32'hFFFF_FFFF);
		write_reg(CFG_HEIGHT, PIX_MAX_DIM + 1);
		send_pixel(1'b1);
		send_pixel(1'b0);
	endtask

	// The generator holds its value through ticks in another mode.
	task automatic test_noise_steps();
		wait_idle();
		write_reg(CFG_SEED, 32'hFFFF_FFFF);
		write_reg(CFG_MODE, CFG_DATA_W'(MODE_NOISE));
		send_pixel(1'b1);
		send_pixel(1'b0);
		wait_idle();
		write_reg(CFG_MODE, CFG_DATA_W'(MODE_SPARE_LO));
		send_pixel(1'b0);
		wait_idle();
		write_reg(CFG_MODE, CFG_DATA_W'(MODE_NOISE));
		send_pixel(1'b0);
		wait_idle();
		write_reg(CFG_SEED, '0);
		send_pixel(1'b1);
	endtask

	task automatic test_diagonal();
		wait_idle();
		write_reg(CFG_MODE, CFG_DATA_W'(MODE_DIAGONAL));
		write_reg(CFG_WIDTH, 4);
		write_reg(CFG_HEIGHT, 4);
		send_pixel(1'b1);
		send_pixel(1'b0);
		send_pixel(1'b0);
		send_pixel(1'b0);
	endtask

	task automatic test_spare_modes();
		wait_idle();
		write_reg(CFG_MODE, CFG_DATA_W'(MODE_SPARE_MID));
		send_pixel(1'b0);
		wait_idle();
		write_reg(CFG_MODE, CFG_DATA_W'(MODE_SPARE_HI));
		send_pixel(1'b0);
	endtask

	// Phases of random settings, each followed by a run of ticks. The
	// counters carry over from phase to phase unless a restart comes.
	task automatic test_random_phases();
		int unsigned run_len;
		while (random_sent < RANDOM_PIXELS) begin
			wait_idle();
			tx_idle_on = ($urandom_range(0, 3) != 0);
			rx_idle_on = ($urandom_range(0, 3) != 0);
			write_reg(CFG_MODE, mode_word(pick_mode()));
			if ($urandom_range(0, 1)) write_reg(CFG_WIDTH, dim_word(pick_dim()));
			if ($urandom_range(0, 1)) write_reg(CFG_HEIGHT, dim_word(pick_dim()));
			if ($urandom_range(0, 2) == 0) write_reg(CFG_SEED, $urandom());
			run_len = $urandom_range(8, 48);
			repeat (run_len) begin
				send_pixel($urandom_range(0, 15) == 0);
				random_sent++;
			end
		end
	endtask

	// Receiver: a random stall before each transfer, or none at all.
	initial begin
		int unsigned stall;
		out_ready = 1'b0;
		forever begin
			stall = rx_idle_on ? $urandom_range(0, 15) : 0;
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			err_count++;
		end
	endtask

	always @(posedge clk) begin
		pixel_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pixels_due.size() == 0) begin
				$error("pixel transfer with nothing pending: %0d,%0d,%0d",
					red, green, blue);
				err_count++;
			end else begin
				want = pixels_due.pop_front();
				check_field("red", 32'(want.red), 32'(red));
				check_field("green", 32'(want.green), 32'(green));
				check_field("blue", 32'(want.blue), 32'(blue));
				check_field("line_end", 32'(want.line_end), 32'(line_end));
				check_field("frame_end", 32'(want.frame_end), 32'(frame_end));
			end
		end
	end

	initial begin
		#10_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_MODE;
		cfg_data  = '0;
		in_valid  = 1'b0;
		restart   = 1'b0;
		reset_model();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		test_default_solid();
		test_gradient_zero_divisor();
		test_gradient_shrink();
		test_checker_oversize();
		test_noise_steps();
		test_diagonal();
		test_spare_modes();
		test_random_phases();

		wait_idle();
		repeat (40) @(posedge clk);
		if (err_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
